// ----- rtl/pph_pkg.sv -----
// shared constants and types for the polyline perimeter and heron area block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pph_pkg;

	localparam int COORD_BITS_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;

	localparam int LEN_W   = 27;
	localparam int AREA_W  = 48;
	localparam int S_W     = LEN_W + 2;
	localparam int F_W     = 2 * S_W;
	localparam int Q_W     = 2 * F_W;
	localparam int AROOT_W = Q_W / 2;

	localparam logic [LEN_W-1:0]  PERIM_MAX = {LEN_W{1'b1}};
	localparam logic [AREA_W-1:0] AREA_MAX  = {AREA_W{1'b1}};

	typedef struct packed {
		logic             vld;
		logic             bad;
		logic [LEN_W-1:0] perim;
	} heron_tag_t;

endpackage

`default_nettype wire

// ----- rtl/pph_if.sv -----
// request channels for points in and results out
// depends on pph_pkg
`timescale 1ns / 1ps
`default_nettype none

interface pph_pts_if #(
	parameter int COORD_BITS = pph_pkg::COORD_BITS_DEF
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] p0_x;
	logic signed [COORD_BITS-1:0] p0_y;
	logic signed [COORD_BITS-1:0] p1_x;
	logic signed [COORD_BITS-1:0] p1_y;
	logic signed [COORD_BITS-1:0] p2_x;
	logic signed [COORD_BITS-1:0] p2_y;
	logic signed [COORD_BITS-1:0] p3_x;
	logic signed [COORD_BITS-1:0] p3_y;

	modport source (output valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
		input ready);
	modport sink (input valid, p0_x, p0_y, p1_x, p1_y, p2_x, p2_y, p3_x, p3_y,
		output ready);
endinterface

interface pph_res_if;
	logic                           valid;
	logic                           ready;
	logic [pph_pkg::LEN_W-1:0]      perimeter;
	logic [pph_pkg::AREA_W-1:0]     area;
	logic                           not_a_triangle;

	modport source (output valid, perimeter, area, not_a_triangle, input ready);
	modport sink (input valid, perimeter, area, not_a_triangle, output ready);
endinterface

`default_nettype wire

// ----- rtl/pph_sqrt_cell.sv -----
// one cell of the square root row: takes two radicand bits, yields one root bit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pph_sqrt_cell #(
	parameter int RAD_W = 4,
	parameter int TAG_W = 1,
	localparam int ROOT_W = RAD_W / 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic [RAD_W-1:0]  rad_in,
	input  wire logic [ROOT_W+1:0] rem_in,
	input  wire logic [ROOT_W-1:0] root_in,
	input  wire logic [TAG_W-1:0]  tag_in,
	output logic      [RAD_W-1:0]  rad_q,
	output logic      [ROOT_W+1:0] rem_q,
	output logic      [ROOT_W-1:0] root_q,
	output logic      [TAG_W-1:0]  tag_q
);

	logic [ROOT_W+1:0] rem_sh;
	logic [ROOT_W+1:0] trial;
	logic              ge;

	always_comb begin
		rem_sh = {rem_in[ROOT_W-1:0], rad_in[RAD_W-1 -: 2]};
		trial  = {root_in, 2'b01};
		ge     = rem_sh >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else if (en) begin
			tag_q <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_q  <= {rad_in[RAD_W-3:0], 2'b00};
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_in[ROOT_W-2:0], ge};
		end
	end

endmodule

`default_nettype wire

// ----- rtl/pph_sqrt_row.sv -----
// row of square root cells, one root bit per cell, tag travels alongside
// depends on pph_sqrt_cell
`timescale 1ns / 1ps
`default_nettype none

module pph_sqrt_row #(
	parameter int RAD_W = 4,
	parameter int TAG_W = 1,
	localparam int ROOT_W = RAD_W / 2
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic [RAD_W-1:0]  rad,
	input  wire logic [TAG_W-1:0]  tag,
	output logic      [ROOT_W-1:0] root,
	output logic      [TAG_W-1:0]  tag_out
);

	logic [RAD_W-1:0]  rad_w  [0:ROOT_W];
	logic [ROOT_W+1:0] rem_w  [0:ROOT_W];
	logic [ROOT_W-1:0] root_w [0:ROOT_W];
	logic [TAG_W-1:0]  tag_w  [0:ROOT_W];

	assign rad_w[0]  = rad;
	assign rem_w[0]  = '0;
	assign root_w[0] = '0;
	assign tag_w[0]  = tag;

	for (genvar i = 0; i < ROOT_W; i++) begin : g_cell
		pph_sqrt_cell #(.RAD_W(RAD_W), .TAG_W(TAG_W)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.rad_in  (rad_w[i]),
			.rem_in  (rem_w[i]),
			.root_in (root_w[i]),
			.tag_in  (tag_w[i]),
			.rad_q   (rad_w[i+1]),
			.rem_q   (rem_w[i+1]),
			.root_q  (root_w[i+1]),
			.tag_q   (tag_w[i+1])
		);
	end

	assign root    = root_w[ROOT_W];
	assign tag_out = tag_w[ROOT_W];

endmodule

`default_nettype wire

// ----- rtl/pph_side.sv -----
// one side length: squared distance, scaled, then a row of root cells
// depends on pph_pkg and pph_sqrt_row
`timescale 1ns / 1ps
`default_nettype none

module pph_side #(
	parameter int COORD_BITS = pph_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = pph_pkg::FRAC_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         en,
	input  wire logic                         vld,
	input  wire logic signed [COORD_BITS-1:0] ax,
	input  wire logic signed [COORD_BITS-1:0] ay,
	input  wire logic signed [COORD_BITS-1:0] bx,
	input  wire logic signed [COORD_BITS-1:0] by,
	output logic      [pph_pkg::LEN_W-1:0]    len,
	output logic                              vld_out
);

	localparam int C      = COORD_BITS;
	localparam int RAD_W  = 2 * C + 2 * FRAC_BITS + 2;
	localparam int ROOT_W = RAD_W / 2;
	localparam int RX     = (ROOT_W > pph_pkg::LEN_W) ? ROOT_W : pph_pkg::LEN_W;

	logic signed [C:0] dfx, dfy;
	logic [C-1:0]      dx_s1, dy_s1;
	logic              vld_s1, vld_s2, vld_s3;
	logic [2*C-1:0]    sqx_s2, sqy_s2;
	logic [RAD_W-1:0]  rad_s3;
	logic [2*C:0]      sum;
	logic [ROOT_W-1:0] root;
	logic [RX-1:0]     root_x;

	always_comb begin
		dfx = {bx[C-1], bx} - {ax[C-1], ax};
		dfy = {by[C-1], by} - {ay[C-1], ay};
		sum = {1'b0, sqx_s2} + {1'b0, sqy_s2};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= dfx[C] ? C'(-dfx) : dfx[C-1:0];
			dy_s1  <= dfy[C] ? C'(-dfy) : dfy[C-1:0];
			sqx_s2 <= dx_s1 * dx_s1;
			sqy_s2 <= dy_s1 * dy_s1;
			rad_s3 <= {1'b0, sum, {(2 * FRAC_BITS){1'b0}}};
		end
	end

	pph_sqrt_row #(.RAD_W(RAD_W), .TAG_W(1)) u_row (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.rad     (rad_s3),
		.tag     (vld_s3),
		.root    (root),
		.tag_out (vld_out)
	);

	always_comb begin
		root_x = RX'(root);
		len    = (root_x > RX'(pph_pkg::PERIM_MAX)) ? pph_pkg::PERIM_MAX
			: root_x[pph_pkg::LEN_W-1:0];
	end

endmodule

`default_nettype wire

// ----- rtl/pph_heron.sv -----
// heron product 16*area^2 from three lengths, split multiply over stages
// depends on pph_pkg
`timescale 1ns / 1ps
`default_nettype none

module pph_heron (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic                       vld,
	input  wire logic [pph_pkg::LEN_W-1:0]  a,
	input  wire logic [pph_pkg::LEN_W-1:0]  b,
	input  wire logic [pph_pkg::LEN_W-1:0]  c,
	output logic      [pph_pkg::Q_W-1:0]    q_s4,
	output pph_pkg::heron_tag_t             tag_s4
);

	localparam int S_W = pph_pkg::S_W;
	localparam int F_W = pph_pkg::F_W;
	localparam int Q_W = pph_pkg::Q_W;
	localparam int H_W = F_W / 2;

	logic [S_W-1:0] s;
	logic [S_W:0]   da, db, dc;
	logic [S_W-1:0] s_s1, da_s1, db_s1, dc_s1;
	logic [F_W-1:0] f_s2, g_s2;
	logic [F_W-1:0] hh_s3, hl_s3, lh_s3, ll_s3;
	logic [Q_W-1:0] q;
	pph_pkg::heron_tag_t tag_s1, tag_s2, tag_s3, tag_n;

	always_comb begin
		s  = S_W'(a) + S_W'(b) + S_W'(c);
		da = {1'b0, s} - {2'b00, a, 1'b0};
		db = {1'b0, s} - {2'b00, b, 1'b0};
		dc = {1'b0, s} - {2'b00, c, 1'b0};
		tag_n.vld   = vld;
		tag_n.bad   = da[S_W] | db[S_W] | dc[S_W];
		tag_n.perim = (s > S_W'(pph_pkg::PERIM_MAX)) ? pph_pkg::PERIM_MAX
			: s[pph_pkg::LEN_W-1:0];
		q = (Q_W'(hh_s3) << F_W) + ((Q_W'(hl_s3) + Q_W'(lh_s3)) << H_W) + Q_W'(ll_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
			tag_s3 <= '0;
			tag_s4 <= '0;
		end else if (en) begin
			tag_s1 <= tag_n;
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
			tag_s4 <= tag_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s_s1  <= s;
			da_s1 <= da[S_W-1:0];
			db_s1 <= db[S_W-1:0];
			dc_s1 <= dc[S_W-1:0];
			f_s2  <= s_s1 * da_s1;
			g_s2  <= db_s1 * dc_s1;
			hh_s3 <= f_s2[F_W-1:H_W] * g_s2[F_W-1:H_W];
			hl_s3 <= f_s2[F_W-1:H_W] * g_s2[H_W-1:0];
			lh_s3 <= f_s2[H_W-1:0] * g_s2[F_W-1:H_W];
			ll_s3 <= f_s2[H_W-1:0] * g_s2[H_W-1:0];
			q_s4  <= tag_s3.bad ? '0 : q;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/polyline_perimeter_heron_area.sv -----
// Takes four points per request and returns the perimeter of the three-side polyline and
// its Heron area. One request is taken every cycle while no finished result is waiting;
// a result passes in order through the squared distance, the side root rows with one
// cell per root bit (COORD_BITS+FRAC_BITS+1 bits), the Heron product, the area root
// row and one output register.
// The whole pipeline holds while a finished result waits to be taken.
// depends on pph_pkg, pph_if, pph_side, pph_heron and pph_sqrt_row
`timescale 1ns / 1ps
`default_nettype none

module polyline_perimeter_heron_area #(
	parameter int COORD_BITS = pph_pkg::COORD_BITS_DEF,
	parameter int FRAC_BITS  = pph_pkg::FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	pph_pts_if.sink  pts,
	pph_res_if.source res
);

	localparam int TAG_W  = $bits(pph_pkg::heron_tag_t);
	localparam int ROOT_W = pph_pkg::AROOT_W;
	localparam int AW     = pph_pkg::AREA_W;

	logic                        en;
	logic                        v0, v1, v2;
	logic [pph_pkg::LEN_W-1:0]   len_a, len_b, len_c;
	logic [pph_pkg::Q_W-1:0]     q;
	pph_pkg::heron_tag_t         tag_h, tag_o;
	logic [TAG_W-1:0]            tag_ov;
	logic [ROOT_W-1:0]           root;
	logic                        res_vld_q;
	logic                        res_bad_q;
	logic [pph_pkg::LEN_W-1:0]   res_perim_q;
	logic [AW-1:0]               res_area_q;

	assign en        = !res_vld_q || res.ready;
	assign pts.ready = en;

	pph_side #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_side_a (
		.clk(clk), .arst_n(arst_n), .en(en), .vld(pts.valid),
		.ax(pts.p0_x), .ay(pts.p0_y), .bx(pts.p1_x), .by(pts.p1_y),
		.len(len_a), .vld_out(v0)
	);

	pph_side #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_side_b (
		.clk(clk), .arst_n(arst_n), .en(en), .vld(pts.valid),
		.ax(pts.p1_x), .ay(pts.p1_y), .bx(pts.p2_x), .by(pts.p2_y),
		.len(len_b), .vld_out(v1)
	);

	pph_side #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_side_c (
		.clk(clk), .arst_n(arst_n), .en(en), .vld(pts.valid),
		.ax(pts.p2_x), .ay(pts.p2_y), .bx(pts.p3_x), .by(pts.p3_y),
		.len(len_c), .vld_out(v2)
	);

	pph_heron u_heron (
		.clk(clk), .arst_n(arst_n), .en(en), .vld(v0),
		.a(len_a), .b(len_b), .c(len_c),
		.q_s4(q), .tag_s4(tag_h)
	);

	pph_sqrt_row #(.RAD_W(pph_pkg::Q_W), .TAG_W(TAG_W)) u_area_row (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.rad     (q),
		.tag     (tag_h),
		.root    (root),
		.tag_out (tag_ov)
	);

	assign tag_o = pph_pkg::heron_tag_t'(tag_ov);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (en) begin
			res_vld_q <= tag_o.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_bad_q   <= tag_o.bad;
			res_perim_q <= tag_o.perim;
			res_area_q  <= (|root[ROOT_W-1:AW+2]) ? pph_pkg::AREA_MAX : root[AW+1:2];
		end
	end

	assign res.valid          = res_vld_q;
	assign res.perimeter      = res_perim_q;
	assign res.area           = res_area_q;
	assign res.not_a_triangle = res_bad_q;

	a_sides_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		v0 == v1 && v1 == v2)
		else $error("side rows out of step");

	a_bad_zero_area: assert property (@(posedge clk) disable iff (!arst_n)
		res_vld_q && res_bad_q |-> res_area_q == '0)
		else $error("area nonzero on a non-triangle");

	a_row_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		tag_o.vld && en |=> res.valid)
		else $error("finished request not presented");

endmodule

`default_nettype wire
